@@ rtl/core/b64_pkg.sv @@
// b64_pkg: shared types, codes and alphabet functions for the base64 codec.
// No dependencies; every other file of the codec imports this package.
`timescale 1ns / 1ps
`default_nettype none

package b64_pkg;

    // Result status codes
    localparam logic [1:0] StatusOk      = 2'd0;
    localparam logic [1:0] StatusBadChar = 2'd1;
    localparam logic [1:0] StatusBadLen  = 2'd2;

    localparam logic [7:0] PadChar = 8'h3D;

    // Job queue between front and back
    localparam int QueueDepth = 2;
    localparam int QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
    localparam int QCountW    = $clog2(QueueDepth + 1);

    // One finished group, ready to be sent out as one to four beats
    typedef struct packed {
        logic        decode;   // 1 decode job, 0 encode job
        logic [23:0] bits;     // gathered 24-bit group
        logic [1:0]  cnt_m1;   // number of result beats minus one
        logic [1:0]  keep_m1;  // encode: alphabet characters minus one, rest is pad
        logic        last;     // job closes the stream
        logic [1:0]  status;   // status carried by every beat of the job
    } b64_job_t;

    // Queue head as seen by the back part
    typedef struct packed {
        logic     valid;
        b64_job_t job;
    } b64_head_t;

    // 6-bit value to alphabet character
    function automatic logic [7:0] b64_char(input logic [5:0] v);
        logic [7:0] c;
        if (v < 6'd26)
            c = 8'h41 + {2'b00, v};
        else if (v < 6'd52)
            c = 8'h61 + {2'b00, v - 6'd26};
        else if (v < 6'd62)
            c = 8'h30 + {2'b00, v - 6'd52};
        else if (v == 6'd62)
            c = 8'h2B;
        else
            c = 8'h2F;
        return c;
    endfunction

    // Character to {invalid, 6-bit value}
    function automatic logic [6:0] b64_value(input logic [7:0] c);
        logic [6:0] r;
        if (c >= 8'h41 && c <= 8'h5A)
            r = {1'b0, 6'(c - 8'h41)};
        else if (c >= 8'h61 && c <= 8'h7A)
            r = {1'b0, 6'(c - 8'h61 + 8'd26)};
        else if (c >= 8'h30 && c <= 8'h39)
            r = {1'b0, 6'(c - 8'h30 + 8'd52)};
        else if (c == 8'h2B)
            r = {1'b0, 6'd62};
        else if (c == 8'h2F)
            r = {1'b0, 6'd63};
        else
            r = {1'b1, 6'd0};
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/b64_front.sv @@
// b64_front: accepts input beats, gathers groups and forms output jobs.
// Depends on b64_pkg; feeds b64_queue.
`timescale 1ns / 1ps
`default_nettype none

module b64_front
    import b64_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     cfg_wr_en,
    input  wire logic     cfg_wr_data,
    input  wire logic     in_valid,
    input  wire logic     in_ready,
    input  wire logic [7:0] in_byte,
    input  wire logic     in_last,
    output logic          push,
    output b64_job_t      push_job
);

    logic        mode_reg;
    logic [23:0] group_bits_reg, group_bits_next;
    logic [1:0]  group_count_reg, group_count_next;
    logic        third_pad_reg, third_pad_next;
    logic        bad_reg, bad_next;

    logic        accept;
    logic [23:0] enc_bits;
    logic [1:0]  enc_count;
    logic [6:0]  dec_val;
    logic        is_pad;
    logic        is_bad;
    logic [5:0]  six;
    logic [23:0] dec_bits;
    logic [1:0]  drop;
    logic        fire;

    assign accept = in_valid && in_ready;

    always_comb
    begin
        // encode: place the byte by its position in the group
        unique case (group_count_reg)
            2'd0:    enc_bits = {in_byte, 16'h0000};
            2'd1:    enc_bits = group_bits_reg | {8'h00, in_byte, 8'h00};
            default: enc_bits = group_bits_reg | {16'h0000, in_byte};
        endcase
        enc_count = group_count_reg + 2'd1;

        // decode: pad counts as zero, invalid characters too
        dec_val  = b64_value(in_byte);
        is_pad   = (in_byte == PadChar);
        is_bad   = !is_pad && dec_val[6];
        six      = (is_pad || is_bad) ? 6'd0 : dec_val[5:0];
        dec_bits = {group_bits_reg[17:0], six};
        drop     = {1'b0, in_last && is_pad} + {1'b0, in_last && third_pad_reg};

        fire             = 1'b0;
        push_job         = '0;
        group_bits_next  = group_bits_reg;
        group_count_next = group_count_reg;
        third_pad_next   = third_pad_reg;
        bad_next         = bad_reg;

        if (!mode_reg)
        begin
            push_job.decode  = 1'b0;
            push_job.bits    = enc_bits;
            push_job.cnt_m1  = 2'd3;
            push_job.keep_m1 = enc_count;
            push_job.last    = in_last;
            push_job.status  = StatusOk;
            fire             = (enc_count == 2'd3) || in_last;
            group_bits_next  = enc_bits;
            group_count_next = enc_count;
        end
        else
        begin
            push_job.decode  = 1'b1;
            push_job.last    = in_last;
            if (group_count_reg == 2'd3)
            begin
                fire            = 1'b1;
                push_job.bits   = dec_bits;
                push_job.cnt_m1 = 2'd2 - drop;
                push_job.status = (bad_reg || is_bad) ? StatusBadChar : StatusOk;
            end
            else if (in_last)
            begin
                // stream ends mid-quad: one zero beat with a length error
                fire            = 1'b1;
                push_job.bits   = '0;
                push_job.cnt_m1 = 2'd0;
                push_job.status = StatusBadLen;
            end
            group_bits_next  = dec_bits;
            group_count_next = group_count_reg + 2'd1;
            bad_next         = bad_reg || is_bad;
            if (group_count_reg == 2'd2)
                third_pad_next = is_pad;
        end

        if (fire)
        begin
            group_bits_next  = '0;
            group_count_next = 2'd0;
            third_pad_next   = 1'b0;
            bad_next         = 1'b0;
        end
    end

    assign push = accept && fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= 1'b0;
            group_bits_reg  <= '0;
            group_count_reg <= 2'd0;
            third_pad_reg   <= 1'b0;
            bad_reg         <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            // new direction: drop any partial group
            mode_reg        <= cfg_wr_data;
            group_bits_reg  <= '0;
            group_count_reg <= 2'd0;
            third_pad_reg   <= 1'b0;
            bad_reg         <= 1'b0;
        end
        else if (accept)
        begin
            group_bits_reg  <= group_bits_next;
            group_count_reg <= group_count_next;
            third_pad_reg   <= third_pad_next;
            bad_reg         <= bad_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/b64_queue.sv @@
// b64_queue: short job queue that decouples the front and back parts.
// Depends on b64_pkg (job type and depth).
`timescale 1ns / 1ps
`default_nettype none

module b64_queue
    import b64_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  b64_job_t      push_job,
    output logic          full,
    input  wire logic     pop,
    output b64_head_t     head
);

    b64_job_t             slot_reg [QueueDepth];
    logic [QPtrW-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [QCountW-1:0]   count_reg;

    assign full       = (count_reg == QCountW'(QueueDepth));
    assign head.valid = (count_reg != '0);
    assign head.job   = slot_reg[rd_ptr_reg];

    function automatic logic [QPtrW-1:0] bump(input logic [QPtrW-1:0] p);
        return (p == QPtrW'(QueueDepth - 1)) ? '0 : p + QPtrW'(1);
    endfunction

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= bump(wr_ptr_reg);
            if (pop)
                rd_ptr_reg <= bump(rd_ptr_reg);
            if (push && !pop)
                count_reg <= count_reg + QCountW'(1);
            else if (pop && !push)
                count_reg <= count_reg - QCountW'(1);
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/b64_back.sv @@
// b64_back: unrolls one job into its result beats through an output register.
// Depends on b64_pkg; drains b64_queue.
`timescale 1ns / 1ps
`default_nettype none

module b64_back
    import b64_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  b64_head_t     head,
    output logic          pop,
    output logic          out_valid,
    input  wire logic     out_stall,
    output logic [7:0]    out_byte,
    output logic          out_last,
    output logic [1:0]    status
);

    b64_job_t    cur_reg;
    logic        cur_valid_reg;
    logic [1:0]  idx_reg;
    logic        out_valid_reg;
    logic [7:0]  out_byte_reg;
    logic        out_last_reg;
    logic [1:0]  status_reg;

    logic        advance;
    logic        emit;
    logic        done;
    logic [5:0]  six;
    logic [7:0]  res_byte;

    assign advance = !out_valid_reg || !out_stall;
    assign emit    = cur_valid_reg && advance;
    assign done    = emit && (idx_reg == cur_reg.cnt_m1);
    assign pop     = head.valid && (!cur_valid_reg || done);

    always_comb
    begin
        case (idx_reg)
            2'd0:    six = cur_reg.bits[23:18];
            2'd1:    six = cur_reg.bits[17:12];
            2'd2:    six = cur_reg.bits[11:6];
            default: six = cur_reg.bits[5:0];
        endcase

        if (cur_reg.decode)
        begin
            case (idx_reg)
                2'd0:    res_byte = cur_reg.bits[23:16];
                2'd1:    res_byte = cur_reg.bits[15:8];
                default: res_byte = cur_reg.bits[7:0];
            endcase
        end
        else if (idx_reg <= cur_reg.keep_m1)
            res_byte = b64_char(six);
        else
            res_byte = PadChar;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_byte_reg <= res_byte;
            out_last_reg <= cur_reg.last && (idx_reg == cur_reg.cnt_m1);
            status_reg   <= cur_reg.status;
        end
        if (pop)
            cur_reg <= head.job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
                out_valid_reg <= cur_valid_reg;
            if (pop)
            begin
                cur_valid_reg <= 1'b1;
                idx_reg       <= 2'd0;
            end
            else if (done)
                cur_valid_reg <= 1'b0;
            else if (emit)
                idx_reg <= idx_reg + 2'd1;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;
    assign status    = status_reg;

endmodule

`default_nettype wire

@@ rtl/core/base64_stream_codec.sv @@
// base64_stream_codec: base64 encoder/decoder on a byte stream, top level.
// Throughput: one input beat per cycle while the job queue has a free slot; one
// result beat per cycle unless the output stalls, so the single-beat output limits encode.
// Reset: asynchronous, active low; mode returns to encode, group and queue empty.
`timescale 1ns / 1ps
`default_nettype none

module base64_stream_codec
    import b64_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    // mode register: 0 encode, 1 decode; a write also drops any partial group
    input  wire logic       cfg_wr_en,
    input  wire logic       cfg_wr_data,
    // input channel
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] in_byte,
    input  wire logic       in_last,
    // output channel
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      out_byte,
    output logic            out_last,
    output logic [1:0]      status
);

    // Front gathers bytes or characters into 24-bit groups and pushes one job per
    // finished group or decode stream ending mid-quad; the back unrolls a job into one to four beats.
    // The queue between them lets the front keep taking input while the back
    // waits on a stalled output.
    logic      push;
    b64_job_t  push_job;
    logic      q_full;
    logic      pop;
    b64_head_t head;

    // Hold input while the job queue has no free slot
    assign in_stall = q_full;

    b64_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (!q_full),
        .in_byte     (in_byte),
        .in_last     (in_last),
        .push        (push),
        .push_job    (push_job)
    );

    b64_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (pop),
        .head     (head)
    );

    b64_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .out_last  (out_last),
        .status    (status)
    );

endmodule

`default_nettype wire

@@ rtl/core/b64_checker.sv @@
// b64_checker: port-level assertions for base64_stream_codec, bound to the top.
// Depends on b64_pkg for status codes and on the top level's ports.
`timescale 1ns / 1ps
`default_nettype none

module b64_checker
    import b64_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_stall,
    input wire logic [7:0] in_byte,
    input wire logic       in_last,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [7:0] out_byte,
    input wire logic       out_last,
    input wire logic [1:0] status
);

    // Once reset has been seen at an edge, no beat leaves and input is not held
    a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid && !in_stall)
        else $error("output beat or input stall right after reset");

    // A stalled input beat holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(in_byte) && $stable(in_last))
        else $error("stalled input beat changed");

    // A stalled output beat holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte)
            && $stable(out_last) && $stable(status))
        else $error("stalled output beat changed");

    // A length error is a single zero beat that closes the stream
    a_badlen_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == StatusBadLen |-> out_last && out_byte == 8'h00)
        else $error("length error beat malformed");

    // Only the defined status codes are produced
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= StatusBadLen)
        else $error("unknown status code");

endmodule

bind base64_stream_codec b64_checker u_b64_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_byte     (in_byte),
    .in_last     (in_last),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .out_last    (out_last),
    .status      (status)
);

`default_nettype wire

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// testbench: self-checking bench for base64_stream_codec in both modes, encode and decode.
// It needs the b64_pkg package for status codes and the pad character, and the codec RTL.
// A queue-fed driver, a result monitor and a bit-exact codec predictor do the checking.

module testbench;
    import b64_pkg::*;

    localparam int CLK_HALF_NS   = 5;
    localparam int RESET_CYCLES  = 12;
    localparam int SETTLE_CYCLES = 8;
    localparam int LIMIT_CYCLES  = 200000;
    localparam int SEGMENT_BEATS = 12;

    localparam logic [8*64-1:0] B64_ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } in_beat_t;

    typedef struct {
        logic [7:0] data;
        logic       last;
        logic [1:0] st;
    } out_beat_t;

    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       cfg_wr_en   = 1'b0;
    logic       cfg_wr_data = 1'b0;
    logic       in_valid    = 1'b0;
    logic       in_stall;
    logic [7:0] in_byte     = 8'h00;
    logic       in_last     = 1'b0;
    logic       out_valid;
    logic       out_stall   = 1'b0;
    logic [7:0] out_byte;
    logic       out_last;
    logic [1:0] status;

    // beats waiting to be sent, and codec results still owed by the block
    in_beat_t  send_beats[$];
    out_beat_t owed_results[$];

    // chance, in percent, that the sender idles or the receiver stalls in a cycle
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    int mismatch_count = 0;
    int cycle_count    = 0;

    // predictor copy of the mode register and the group state
    logic        pred_mode   = MODE_ENCODE;
    logic [23:0] grp_bits    = '0;
    logic [1:0]  grp_cnt     = '0;
    logic        third_pad   = 1'b0;
    logic        bad_seen    = 1'b0;

    base64_stream_codec dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_byte    (in_byte),
        .in_last    (in_last),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .out_last   (out_last),
        .status     (status)
    );

    initial
    begin
        forever
        begin
            #CLK_HALF_NS clk = ~clk;
        end
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic logic [7:0] alpha_char(input logic [5:0] v);
        return B64_ALPHABET[8 * (63 - v) +: 8];
    endfunction

    // Look the character up in the alphabet; -1 when it is not there.
    function automatic int sextet_of(input logic [7:0] c);
        for (int i = 0; i < 64; i++)
        begin
            if (alpha_char(6'(i)) == c)
                return i;
        end
        return -1;
    endfunction

    function automatic void clear_group();
        grp_bits  = '0;
        grp_cnt   = '0;
        third_pad = 1'b0;
        bad_seen  = 1'b0;
    endfunction

    function automatic void owe(input logic [7:0] d, input logic l, input logic [1:0] s);
        out_beat_t r;
        r.data = d;
        r.last = l;
        r.st   = s;
        owed_results.push_back(r);
    endfunction

    // Advance the predictor by one accepted beat and queue the results it owes.
    function automatic void predict_codec(input logic [7:0] b, input logic l);
        int          keep;
        int          count;
        int          sx;
        logic        pad;
        logic [5:0]  v;
        logic [1:0]  st;
        logic [7:0]  c;
        if (pred_mode == MODE_ENCODE)
        begin
            grp_bits = grp_bits | (24'(b) << (16 - 8 * grp_cnt));
            grp_cnt  = grp_cnt + 2'd1;
            // a full group, or whatever is gathered when the stream ends
            if (grp_cnt == 2'd3 || l)
            begin
                keep = int'(grp_cnt) + 1;
                for (int k = 0; k < 4; k++)
                begin
                    c = (k < keep) ? alpha_char(grp_bits[23 - 6 * k -: 6]) : PadChar;
                    owe(c, l && k == 3, StatusOk);
                end
                clear_group();
            end
        end
        else
        begin
            pad = (b == PadChar);
            v   = '0;
            if (!pad)
            begin
                sx = sextet_of(b);
                // an invalid character counts as zero and taints the quad
                if (sx < 0)
                    bad_seen = 1'b1;
                else
                    v = 6'(sx);
            end
            if (grp_cnt == 2'd2)
                third_pad = pad;
            grp_bits = {grp_bits[17:0], v};
            if (grp_cnt == 2'd3)
            begin
                count = 3;
                st    = bad_seen ? StatusBadChar : StatusOk;
                // pads drop bytes only in the quad that closes the stream
                if (l)
                begin
                    if (pad)
                        count--;
                    if (third_pad)
                        count--;
                end
                for (int k = 0; k < count; k++)
                    owe(grp_bits[23 - 8 * k -: 8], l && k + 1 == count, st);
                clear_group();
            end
            else
            begin
                grp_cnt = grp_cnt + 2'd1;
                // stream ends mid-quad: one bad-length result, group dropped
                if (l)
                begin
                    owe(8'h00, 1'b1, StatusBadLen);
                    clear_group();
                end
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Driver: hold the beat while stalled, otherwise maybe idle, else advance
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin : drive_input
        in_beat_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                predict_codec(in_byte, in_last);
            if (!(in_valid && in_stall))
            begin
                if (send_beats.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    nxt = send_beats.pop_front();
                    in_valid <= 1'b1;
                    in_byte  <= nxt.data;
                    in_last  <= nxt.last;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each result beat with the oldest owed result
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what);
        $display("ERROR @%0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin : watch_output
        out_beat_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (owed_results.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result beat byte=%02h last=%0b status=%0d",
                                              out_byte, out_last, status));
                end
                else
                begin
                    want = owed_results.pop_front();
                    if (out_byte !== want.data)
                        report_mismatch($sformatf("out_byte %02h, want %02h", out_byte, want.data));
                    if (out_last !== want.last)
                        report_mismatch($sformatf("out_last %0b, want %0b", out_last, want.last));
                    if (status !== want.st)
                        report_mismatch($sformatf("status %0d, want %0d", status, want.st));
                end
            end
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // Guard against a hung block.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("base64_stream_codec test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    task automatic queue_beat(input logic [7:0] d, input logic l);
        in_beat_t b;
        b.data = d;
        b.last = l;
        send_beats.push_back(b);
    endtask

    task automatic queue_text(input string s, input logic close);
        for (int i = 0; i < s.len(); i++)
            queue_beat(s[i], close && i == s.len() - 1);
    endtask

    // Hold until every beat is sent and every owed result is in, then let the
    // block settle: a beat that closes no group leaves nothing to wait on.
    task automatic wait_drained();
        while (send_beats.size() != 0 || in_valid || owed_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write the mode register while idle; the write also drops any partial group.
    task automatic write_mode(input logic m);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= m;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        pred_mode = m;
        clear_group();
    endtask

    // Encode streams of random bytes, mostly short, each closed by a last beat.
    task automatic queue_encode_streams(input int n_beats);
        int sent;
        int len;
        sent = 0;
        while (sent < n_beats)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 13) : $urandom_range(1, 7);
            for (int i = 0; i < len; i++)
                queue_beat(8'($urandom), i == len - 1);
            sent += len;
        end
    endtask

    // Decode streams: most are well-formed quads with random characters and
    // random final padding; the rest is noise with bad characters, stray pads
    // and lengths that break off mid-quad.
    task automatic queue_decode_streams(input int n_beats);
        int         sent;
        int         quads;
        int         tail;
        int         len;
        int         pick;
        logic [7:0] chars[$];
        sent = 0;
        while (sent < n_beats)
        begin
            chars.delete();
            if ($urandom_range(0, 99) < 80)
            begin
                quads = $urandom_range(1, 3);
                for (int i = 0; i < 4 * quads; i++)
                    chars.push_back(alpha_char(6'($urandom_range(0, 63))));
                tail = $urandom_range(0, 2);
                if (tail >= 1)
                    chars[4 * quads - 1] = PadChar;
                if (tail == 2)
                    chars[4 * quads - 2] = PadChar;
                // a pad inside an earlier quad still counts as zero
                if (quads > 1 && $urandom_range(0, 9) == 0)
                    chars[$urandom_range(0, 3)] = PadChar;
            end
            else
            begin
                len = $urandom_range(1, 9);
                for (int i = 0; i < len; i++)
                begin
                    pick = $urandom_range(0, 3);
                    if (pick < 2)
                        chars.push_back(alpha_char(6'($urandom_range(0, 63))));
                    else if (pick == 2)
                        chars.push_back(PadChar);
                    else
                        chars.push_back(8'($urandom));
                end
            end
            foreach (chars[i])
                queue_beat(chars[i], i == chars.size() - 1);
            sent += chars.size();
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed encode, mode left at its reset value: one byte gives two
        // pads, two bytes give one pad, a full group gives none.
        queue_beat(8'h00, 1'b1);
        queue_beat(8'hFF, 1'b0);
        queue_beat(8'hFF, 1'b1);
        queue_beat(8'hFB, 1'b0);
        queue_beat(8'hEF, 1'b0);
        queue_beat(8'hBE, 1'b1);
        // leave a partial group behind; the mode write must drop it
        queue_beat(8'h12, 1'b0);
        queue_beat(8'h34, 1'b0);
        write_mode(MODE_DECODE);

        // Directed decode: pads in a middle quad, one trailing pad, bad
        // characters at both byte extremes with two trailing pads, a short
        // stream with a bad character (bad length wins), then a dangling pair.
        queue_text("TQ==", 1'b0);
        queue_text("TWE=", 1'b1);
        queue_beat(8'h00, 1'b0);
        queue_beat(8'hFF, 1'b0);
        queue_beat(PadChar, 1'b0);
        queue_beat(PadChar, 1'b1);
        queue_text("*W", 1'b1);
        queue_text("AB", 1'b0);
        write_mode(MODE_ENCODE);

        // Random part: each idling phase in both modes.
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 85;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 85;
                end
                default:
                begin
                    send_idle_pct  = 9;
                    recv_stall_pct = 9;
                end
            endcase
            write_mode(MODE_ENCODE);
            queue_encode_streams(SEGMENT_BEATS / 2);
            // hold the sender until the block has drained, then go on
            wait_drained();
            queue_encode_streams(SEGMENT_BEATS / 2);
            write_mode(MODE_DECODE);
            queue_decode_streams(SEGMENT_BEATS);
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("base64_stream_codec test passed");
        else
            $display("base64_stream_codec test failed");
        $finish;
    end

endmodule
